@@ rtl/core/hhs_pkg.sv @@
package hhs_pkg;

    localparam int NUM_TASKS = 8;
    localparam int MASK_BITS = 8;
    localparam int ID_W      = 4;
    localparam int CNT_W     = 8;

    localparam logic [CNT_W-1:0] MISS_MAX        = 8'hFF;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd5;

    localparam logic REQ_BEAT  = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    // command from the front end to the task bank, one transaction per cycle at most
    typedef struct packed {
        logic            beat;
        logic            check;
        logic [ID_W-1:0] id;
    } hhs_cmd_t;

endpackage

@@ rtl/core/heartbeat_hang_supervisor.sv @@
// A check transaction waits in the input register until the result register has room,
// and is then loaded into the result register; heartbeats give no result.
// Throughput: one transaction per cycle; heartbeats always pass, and a check stalls the
// input only while the result register is full and m_tready is low.
// Reset (aresetn low, synchronous): all seen bits, miss counters and the hang
// flag clear, both registers empty, hang_threshold returns to 5.
module heartbeat_hang_supervisor (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: hang_threshold
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] task_id, [7:4] zero
    input  logic [0:0]  s_tuser,   // [0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] feed_watchdog, [1] hang_flag, [9:2] hung_mask,
                                   // [10] hang_raised, [11] hang_cleared, [15:12] zero
);
    import hhs_pkg::*;

    logic [CNT_W-1:0]     threshold_reg;
    logic                 in_vld_reg;
    logic                 in_type_reg;
    logic [ID_W-1:0]      in_id_reg;
    logic                 consume;
    hhs_cmd_t             cmd;
    logic [NUM_TASKS-1:0] hung;
    logic                 any_hung;
    logic [MASK_BITS-1:0] mask_next;
    logic                 hang_error_reg;
    logic                 out_vld_reg;
    logic                 feed_reg;
    logic                 flag_reg;
    logic [MASK_BITS-1:0] mask_reg;
    logic                 raised_reg;
    logic                 cleared_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_valid) begin
            threshold_reg <= cfg_data;
        end
    end

    // a heartbeat never waits; a check waits for room in the result register
    assign consume  = in_vld_reg &&
                      ((in_type_reg == REQ_BEAT) || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_type_reg <= s_tuser[0];
            in_id_reg   <= s_tdata[ID_W-1:0];
        end
    end

    assign cmd.beat  = consume && (in_type_reg == REQ_BEAT);
    assign cmd.check = consume && (in_type_reg == REQ_CHECK);
    assign cmd.id    = in_id_reg;

    hhs_task_bank u_bank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .threshold (threshold_reg),
        .hung      (hung)
    );

    assign any_hung = |hung;

    always_comb begin
        for (int b = 0; b < MASK_BITS; b++) begin
            mask_next[b] = (b < NUM_TASKS) ? hung[b % NUM_TASKS] : 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hang_error_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
        end else begin
            if (cmd.check) begin
                hang_error_reg <= any_hung;
                out_vld_reg    <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            feed_reg    <= !any_hung;
            flag_reg    <= any_hung;
            mask_reg    <= mask_next;
            raised_reg  <= any_hung && !hang_error_reg;
            cleared_reg <= !any_hung && hang_error_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000, cleared_reg, raised_reg, mask_reg, flag_reg, feed_reg};

`ifndef SYNTHESIS
    a_raise_sets_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && raised_reg |-> flag_reg && !cleared_reg)
        else $error("hang raised without flag");
    a_clear_feeds : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cleared_reg |-> !flag_reg && feed_reg)
        else $error("hang cleared while still hung");
    a_feed_vs_flag : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (feed_reg != flag_reg))
        else $error("feed and hang flag disagree");
    a_check_gives_result : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.check |=> m_tvalid && (flag_reg == hang_error_reg))
        else $error("check transaction lost its result");
`endif

endmodule

@@ rtl/core/hhs_task_bank.sv @@
module hhs_task_bank (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  hhs_pkg::hhs_cmd_t              cmd,
    input  logic [hhs_pkg::CNT_W-1:0]      threshold,
    output logic [hhs_pkg::NUM_TASKS-1:0]  hung
);
    import hhs_pkg::*;

    logic [NUM_TASKS-1:0] seen_reg;
    logic [NUM_TASKS-1:0] seen_next;
    logic [CNT_W-1:0]     miss_reg  [NUM_TASKS];
    logic [CNT_W-1:0]     miss_next [NUM_TASKS];
    logic [CNT_W-1:0]     miss_inc  [NUM_TASKS];

    always_comb begin
        for (int t = 0; t < NUM_TASKS; t++) begin
            miss_inc[t] = (miss_reg[t] == MISS_MAX) ? miss_reg[t] : miss_reg[t] + 1'b1;
            // hung only if the task missed this period
            hung[t]      = !seen_reg[t] && (miss_inc[t] >= threshold);
            seen_next[t] = seen_reg[t];
            miss_next[t] = miss_reg[t];
            if (cmd.check) begin
                seen_next[t] = 1'b0;
                miss_next[t] = seen_reg[t] ? '0 : miss_inc[t];
            end else if (cmd.beat && (cmd.id == ID_W'(t))) begin
                seen_next[t] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            for (int t = 0; t < NUM_TASKS; t++) begin
                miss_reg[t] <= '0;
            end
        end else begin
            seen_reg <= seen_next;
            for (int t = 0; t < NUM_TASKS; t++) begin
                miss_reg[t] <= miss_next[t];
            end
        end
    end

endmodule

@@ bench/hhs_report_checker.sv @@
`timescale 1ns / 1ps

module hhs_report_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] task_id, [7:4] zero
    input  logic [0:0]  s_tuser,   // [0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [0] feed, [1] flag, [9:2] mask, [10] raised, [11] cleared
    output int          mismatches,
    output int          reports_due
);
    import hhs_pkg::*;

    localparam int TASK_W = $clog2(NUM_TASKS);

    // packed so that the lowest bits line up with m_tdata
    typedef struct packed {
        logic                 cleared;
        logic                 raised;
        logic [MASK_BITS-1:0] mask;
        logic                 flag;
        logic                 feed;
    } hang_report_t;

    logic [NUM_TASKS-1:0] beat_seen;
    logic [CNT_W-1:0]     miss_count [NUM_TASKS];
    logic                 hang_latched;
    logic [CNT_W-1:0]     threshold;
    hang_report_t         expected_reports [$];

    // one check period over all tasks; updates the shadow state
    function automatic hang_report_t fold_check();
        hang_report_t         rpt;
        logic                 any_hung;
        logic [MASK_BITS-1:0] mask;
        int                   t;
        any_hung = 1'b0;
        mask     = '0;
        for (t = 0; t < NUM_TASKS; t++) begin
            if (beat_seen[t]) begin
                beat_seen[t]  = 1'b0;
                miss_count[t] = '0;
            end else begin
                if (miss_count[t] != MISS_MAX)
                    miss_count[t] = miss_count[t] + 1'b1;
                if (miss_count[t] >= threshold) begin
                    any_hung = 1'b1;
                    if (t < MASK_BITS)
                        mask[t] = 1'b1;
                end
            end
        end
        rpt.raised   = any_hung && !hang_latched;
        rpt.cleared  = !any_hung && hang_latched;
        hang_latched = any_hung;
        rpt.flag     = any_hung;
        rpt.feed     = !any_hung;
        rpt.mask     = mask;
        return rpt;
    endfunction

    always @(posedge aclk) begin
        hang_report_t    want;
        hang_report_t    got;
        logic [ID_W-1:0] id;
        if (!aresetn) begin
            mismatches   = 0;
            beat_seen    = '0;
            hang_latched = 1'b0;
            threshold    = THRESHOLD_RESET;
            for (int t = 0; t < NUM_TASKS; t++)
                miss_count[t] = '0;
            expected_reports.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(hang_report_t)-1:0];
                if (expected_reports.size() == 0) begin
                    $error("result transaction with no check outstanding: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.feed !== want.feed) begin
                        $error("feed_watchdog: expected %0d, got %0d", want.feed, got.feed);
                        mismatches++;
                    end
                    if (got.flag !== want.flag) begin
                        $error("hang_flag: expected %0d, got %0d", want.flag, got.flag);
                        mismatches++;
                    end
                    if (got.mask !== want.mask) begin
                        $error("hung_mask: expected %h, got %h", want.mask, got.mask);
                        mismatches++;
                    end
                    if (got.raised !== want.raised) begin
                        $error("hang_raised: expected %0d, got %0d", want.raised, got.raised);
                        mismatches++;
                    end
                    if (got.cleared !== want.cleared) begin
                        $error("hang_cleared: expected %0d, got %0d",
                               want.cleared, got.cleared);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                threshold = cfg_data;
            if (s_tvalid && s_tready) begin
                id = s_tdata[ID_W-1:0];
                if (s_tuser[0] == REQ_CHECK)
                    expected_reports.push_back(fold_check());
                else if (id < NUM_TASKS)
                    beat_seen[id[TASK_W-1:0]] = 1'b1;
            end
        end
        reports_due = expected_reports.size();
    end

endmodule

@@ bench/heartbeat_hang_supervisor_test.sv @@
`timescale 1ns / 1ps

module heartbeat_hang_supervisor_test;
    import hhs_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN       = 6;
    localparam int TASK_W      = $clog2(NUM_TASKS);

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [3:0] task_id, [7:4] zero
    logic [0:0]  s_tuser   = '0;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [0] feed, [1] flag, [9:2] mask, [10] raised, [11] cleared

    int mismatches;
    int reports_due;
    int cycle_count = 0;
    bit tx_idle     = 1'b0;
    bit rx_idle     = 1'b0;
    bit hold_output = 1'b0;

    always #2 aclk = ~aclk;

    heartbeat_hang_supervisor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    hhs_report_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .reports_due (reports_due)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("heartbeat_hang_supervisor_test: done, errors");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_output = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 16) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_item(input logic kind, input logic [ID_W-1:0] id);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, id};
        do @(posedge aclk); while (!s_tready);
    endtask

    // all results in, then let any heartbeat still in the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reports_due != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // check periods: live tasks beat most of the time, dead ones get only stray random beats
    task automatic run_periods(input int periods, input bit pinned,
                               input logic [NUM_TASKS-1:0] dead_init);
        logic [NUM_TASKS-1:0] dead;
        int                   p;
        int                   t;
        dead = dead_init;
        for (p = 0; p < periods; p++) begin
            if (!pinned && (p % 16 == 0))
                dead = ($urandom_range(0, 3) == 0) ? '0 : NUM_TASKS'($urandom & $urandom);
            if (!pinned && $urandom_range(0, 40) == 0)
                dead[TASK_W'($urandom_range(0, NUM_TASKS - 1))] ^= 1'b1;
            for (t = 0; t < NUM_TASKS; t++)
                if (!dead[t] && $urandom_range(0, 7) != 0)
                    send_item(REQ_BEAT, ID_W'(t));
            if ($urandom_range(0, 5) == 0)
                send_item(REQ_BEAT, ID_W'($urandom_range(0, 15)));
            if ($urandom_range(0, 12) == 0)
                send_item(REQ_CHECK, ID_W'($urandom_range(0, 15)));
            send_item(REQ_CHECK, ID_W'($urandom_range(0, 15)));
        end
    endtask

    task automatic pick_idling();
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
    endtask

    initial begin
        int t;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default threshold, one miss is not a hang
        send_item(REQ_CHECK, 4'h0);
        write_threshold(8'd1);
        // out-of-range ids are dropped, so every task hangs
        send_item(REQ_BEAT, 4'hF);
        send_item(REQ_BEAT, 4'h8);
        send_item(REQ_CHECK, 4'hF);
        // all tasks alive again: flag clears
        for (t = 0; t < NUM_TASKS; t++)
            send_item(REQ_BEAT, ID_W'(t));
        send_item(REQ_CHECK, 4'h0);
        send_item(REQ_BEAT, 4'h0);
        send_item(REQ_CHECK, 4'h0);
        send_item(REQ_CHECK, 4'h5);
        // zero threshold: only tasks that missed this period are hung
        write_threshold(8'd0);
        send_item(REQ_BEAT, 4'h3);
        send_item(REQ_CHECK, 4'hA);

        write_threshold(8'd2);
        pick_idling();
        run_periods(28, 1'b0, '0);

        write_threshold(8'd1);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        run_periods(12, 1'b0, '0);
        // output held off while the input keeps offering checks
        hold_output = 1'b1;
        repeat (40) send_item(REQ_CHECK, ID_W'($urandom_range(0, 15)));
        run_periods(12, 1'b0, '0);

        write_threshold(8'd3);
        pick_idling();
        run_periods(28, 1'b0, '0);

        write_threshold(8'd0);
        pick_idling();
        run_periods(20, 1'b0, '0);

        // max threshold; silent tasks run their counters into saturation
        write_threshold(8'd255);
        pick_idling();
        run_periods(262, 1'b1, {{(NUM_TASKS - 1){1'b1}}, 1'b0});

        write_threshold(8'($urandom_range(1, 8)));
        pick_idling();
        run_periods(24, 1'b0, '0);

        write_threshold(8'd5);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_periods(20, 1'b0, '0);

        wait_idle();
        if (mismatches == 0)
            $display("heartbeat_hang_supervisor_test: done, clean");
        else
            $display("heartbeat_hang_supervisor_test: done, errors");
        $finish;
    end

endmodule
